FILE: hw/rtl/sfe_pkg.sv
// Shared types and constants for the serial frame encoder.
// Used by sfe_front, sfe_queue, sfe_back and serial_frame_encoder.
package sfe_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] ChStart = 8'h23;  // '#'
  localparam logic [7:0] ChBase  = 8'h3D;  // '='
  localparam logic [7:0] ChCr    = 8'h0D;  // carriage return
  localparam logic [7:0] ChLowA  = 8'h61;  // 'a'

  localparam logic [4:0] AddrReset = 5'd1;

  // One unit of work for the character sequencer
  typedef struct packed {
    logic        first;      // emit header
    logic [7:0]  cmd;
    logic        grp;        // emit one group of four characters
    logic [23:0] grp_bytes;  // {a, b, c}
    logic        last;       // emit trailer
  } sfe_job_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_ADDR,
    ST_CMD,
    ST_G0,
    ST_G1,
    ST_G2,
    ST_G3,
    ST_SUM_HI,
    ST_SUM_LO,
    ST_CR
  } sfe_step_t;

endpackage

FILE: hw/rtl/sfe_front.sv
// Front end: accepts input items, collects payload bytes into groups of three
// and makes a queue job of each item that yields characters. Uses sfe_pkg.
module sfe_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [15:0]       in_tdata,   // [7:0] command, [15:8] data_byte
  input  logic              in_tlast,   // last_item
  input  logic [1:0]        in_tuser,   // [0] has_data, [1] first_item
  input  logic              q_full,
  output logic              push,
  output sfe_pkg::sfe_job_t job
);
  import sfe_pkg::*;

  logic [7:0] a_r, a_nxt;
  logic [7:0] b_r, b_nxt;
  logic [1:0] pos_r, pos_nxt;
  logic [1:0] pos_start, pos_mid;
  logic [7:0] cmd, data;
  logic       has_data, first, last;
  logic       grp;
  logic [23:0] grp_bytes;
  logic       accept;

  assign cmd      = in_tdata[7:0];
  assign data     = in_tdata[15:8];
  assign has_data = in_tuser[0];
  assign first    = in_tuser[1];
  assign last     = in_tlast;

  always_comb begin
    a_nxt     = a_r;
    b_nxt     = b_r;
    grp       = 1'b0;
    grp_bytes = 24'h000000;
    // a new frame drops whatever was held
    pos_start = first ? 2'd0 : pos_r;
    pos_mid   = pos_start;
    if (has_data) begin
      case (pos_start)
        2'd0: begin
          a_nxt   = data;
          pos_mid = 2'd1;
        end
        2'd1: begin
          b_nxt   = data;
          pos_mid = 2'd2;
        end
        default: begin
          grp       = 1'b1;
          grp_bytes = {a_r, b_r, data};
          pos_mid   = 2'd0;
        end
      endcase
    end
    pos_nxt = pos_mid;
    if (last) begin
      // pad a short group with zero bytes
      if (pos_mid != 2'd0) begin
        grp       = 1'b1;
        grp_bytes = {a_nxt, (pos_mid == 2'd2) ? b_nxt : 8'h00, 8'h00};
      end
      pos_nxt = 2'd0;
    end
  end

  assign in_tready = !q_full;
  assign accept    = in_tvalid && !q_full;
  // drop items that produce no characters
  assign push      = accept && (first || grp || last);

  always_comb begin
    job.first     = first;
    job.cmd       = cmd;
    job.grp       = grp;
    job.grp_bytes = grp_bytes;
    job.last      = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 2'd0;
    end else if (accept) begin
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_r <= a_nxt;
      b_r <= b_nxt;
    end
  end

endmodule

FILE: hw/rtl/sfe_queue.sv
// Small job queue between front end and character sequencer.
// Depends on sfe_pkg for the job type.
module sfe_queue #(
  parameter int unsigned DEPTH = sfe_pkg::QueueDepth
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sfe_pkg::sfe_job_t wr_job,
  input  logic              pop,
  output logic              full,
  output logic              head_valid,
  output sfe_pkg::sfe_job_t head_job
);
  import sfe_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  sfe_job_t            mem_r [DEPTH];
  logic [PtrW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0]     count_r;
  logic                do_push, do_pop;

  assign full       = (count_r == CntW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/sfe_back.sv
// Back end: steps through the characters of each job, keeps the running
// checksum and the device address, and drives the output register. Uses sfe_pkg.
module sfe_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  input  logic [4:0]        cfg_data,
  input  logic              head_valid,
  input  sfe_pkg::sfe_job_t head_job,
  output logic              pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,
  output logic              out_tlast
);
  import sfe_pkg::*;

  sfe_step_t   step_r, step_nxt, cur_step, after_step;
  logic [11:0] csum_r, csum_nxt;
  logic [5:0]  slo_r;
  logic [4:0]  addr_r;
  logic        out_valid_r;
  logic [7:0]  out_char_r;
  logic        out_last_r;
  logic [7:0]  ch;
  logic        emit, done;

  assign emit = head_valid && (!out_valid_r || out_tready);

  // next step
  always_comb begin
    if (step_r == ST_IDLE) begin
      cur_step = head_job.first ? ST_START : (head_job.grp ? ST_G0 : ST_SUM_HI);
    end else begin
      cur_step = step_r;
    end
    case (cur_step)
      ST_START:  after_step = ST_ADDR;
      ST_ADDR:   after_step = ST_CMD;
      ST_CMD:    after_step = head_job.grp ? ST_G0 : (head_job.last ? ST_SUM_HI : ST_IDLE);
      ST_G0:     after_step = ST_G1;
      ST_G1:     after_step = ST_G2;
      ST_G2:     after_step = ST_G3;
      ST_G3:     after_step = head_job.last ? ST_SUM_HI : ST_IDLE;
      ST_SUM_HI: after_step = ST_SUM_LO;
      ST_SUM_LO: after_step = ST_CR;
      ST_CR:     after_step = ST_IDLE;
      default:   after_step = ST_IDLE;
    endcase
    done     = (after_step == ST_IDLE);
    step_nxt = emit ? after_step : step_r;
  end

  // character and checksum
  always_comb begin
    case (cur_step)
      ST_START:  ch = ChStart;
      ST_ADDR:   ch = ChLowA + {3'b000, addr_r};
      ST_CMD:    ch = head_job.cmd;
      ST_G0:     ch = ChBase + {2'b00, head_job.grp_bytes[23:18]};
      ST_G1:     ch = ChBase + {2'b00, head_job.grp_bytes[17:12]};
      ST_G2:     ch = ChBase + {2'b00, head_job.grp_bytes[11:6]};
      ST_G3:     ch = ChBase + {2'b00, head_job.grp_bytes[5:0]};
      ST_SUM_HI: ch = ChBase + {2'b00, csum_r[11:6]};
      ST_SUM_LO: ch = ChBase + {2'b00, slo_r};
      ST_CR:     ch = ChCr;
      default:   ch = 8'h00;
    endcase
    case (cur_step)
      ST_START: csum_nxt = {4'h0, ch};
      ST_CR:    csum_nxt = 12'h000;
      default:  csum_nxt = csum_r + {4'h0, ch};
    endcase
  end

  assign pop = emit && done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= ST_IDLE;
      csum_r      <= 12'h000;
      out_valid_r <= 1'b0;
      addr_r      <= AddrReset;
    end else begin
      step_r <= step_nxt;
      if (emit) begin
        csum_r <= csum_nxt;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) begin
        addr_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_char_r <= ch;
      out_last_r <= done;
      // hold low half of the sum taken before the trailer started
      if (cur_step == ST_SUM_HI) begin
        slo_r <= csum_r[5:0];
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tlast  = out_last_r;

endmodule

FILE: hw/rtl/serial_frame_encoder.sv
// Serial frame encoder: payload items in, frame characters out.
// Instantiates sfe_front, sfe_queue and sfe_back; uses sfe_pkg.
//
// Input channel in_*: one item per handshake carries command and data_byte in
// in_tdata, has_data and first_item in in_tuser, last_item in in_tlast.
// Output channel out_*: one frame character per handshake in out_tdata; out_tlast
// marks the final character caused by one input item.
// Configuration channel cfg_*: device address, always ready; write it while
// the block is idle.
// Flow: an accepted item is written into the job queue, and its first character
// is then registered in the output register. The sequencer emits one character
// per cycle while the receiver is ready: a byte that closes a group of three
// yields 4 characters, a header 3, a trailer 3 (plus 4 for a padded group);
// bytes that only fill a group take no sequencer time. A two-entry job queue
// lets input be taken while the sequencer is still busy.
// Reset: synchronous, active low; clears the queue, the running checksum,
// the group position and sets the device address to 1.
// When the receiver stalls, the output register holds its character, the
// sequencer waits, and input is taken until the job queue fills.
module serial_frame_encoder #(
  parameter int unsigned QUEUE_DEPTH = sfe_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] command, [15:8] data_byte
  input  logic        in_tlast,   // last_item
  input  logic [1:0]  in_tuser,   // [0] has_data, [1] first_item
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_char
  output logic        out_tlast,  // last_of_run
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data
);
  import sfe_pkg::*;

  sfe_job_t front_job, head_job;
  logic     push, q_full, head_valid, pop;

  assign cfg_ready = 1'b1;

  sfe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .push      (push),
    .job       (front_job)
  );

  sfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .wr_job     (front_job),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  sfe_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

`ifndef SYNTHESIS
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("job popped from empty queue");

  a_pop_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (out_tvalid && out_tlast))
    else $error("finished job did not end its run");

  a_last_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |-> push)
    else $error("closing item produced no job");

  a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> head_valid)
    else $error("queue full and empty at once");
`endif

endmodule

FILE: bench/tb_serial_frame_encoder.sv
`timescale 1ns / 1ps
// Self-checking bench for serial_frame_encoder: drives payload items, predicts
// the frame characters in step with each accepted item and checks every output.
// Depends on sfe_pkg for the framing characters and on the encoder RTL.
module tb_serial_frame_encoder;
  import sfe_pkg::*;

  localparam int CycleLimit   = 200000;
  localparam int SettleCycles = 20;
  localparam int LongHold     = 400;

  typedef struct packed {
    logic [7:0] cmd;
    logic [7:0] data;
    logic       has_data;
    logic       first;
    logic       last;
  } frame_item_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       tail;
  } frame_char_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // [7:0] command, [15:8] data_byte
  logic        in_tlast = 1'b0; // last_item
  logic [1:0]  in_tuser = '0;   // [0] has_data, [1] first_item
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // [7:0] out_char
  logic        out_tlast;       // last_of_run
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_data = '0;

  serial_frame_encoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  frame_item_t pending_items[$];
  frame_char_t expected_chars[$];
  logic [7:0]  run_chars[$];

  // Encoder state as seen by the prediction
  logic [4:0]  dev_address = AddrReset;
  logic [11:0] frame_sum = '0;
  logic [7:0]  held_a = '0;
  logic [7:0]  held_b = '0;
  logic [1:0]  group_pos = '0;

  int   errors = 0;
  int   cycle_count = 0;
  int   hold_left = 0;
  logic hold_armed = 1'b0;
  logic hold_done = 1'b0;
  logic calm;

  assign calm = (cycle_count >= 600) && (cycle_count < 1000);

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic add_char(input logic [7:0] c);
    run_chars.push_back(c);
    frame_sum = frame_sum + {4'b0000, c};
  endtask

  task automatic add_group(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c);
    add_char(ChBase + {2'b00, a[7:2]});
    add_char(ChBase + {2'b00, a[1:0], b[7:4]});
    add_char(ChBase + {2'b00, b[3:0], c[7:6]});
    add_char(ChBase + {2'b00, c[5:0]});
  endtask

  task automatic clear_frame();
    frame_sum = '0;
    held_a    = '0;
    held_b    = '0;
    group_pos = '0;
  endtask

  // Work out the characters one accepted item causes, in transmit order
  task automatic encode_item(input logic [7:0] cmd, input logic [7:0] data,
                             input logic has_data, input logic first, input logic last);
    logic [11:0] sum_now;
    run_chars.delete();
    if (first) begin
      clear_frame();
      add_char(ChStart);
      add_char(ChLowA + {3'b000, dev_address});
      add_char(cmd);
    end
    if (has_data) begin
      case (group_pos)
        2'd0: begin
          held_a    = data;
          held_b    = '0;
          group_pos = 2'd1;
        end
        2'd1: begin
          held_b    = data;
          group_pos = 2'd2;
        end
        default: begin
          add_group(held_a, held_b, data);
          held_a    = '0;
          held_b    = '0;
          group_pos = '0;
        end
      endcase
    end
    if (last) begin
      // Pad a short group with zero bytes
      if (group_pos != 2'd0)
        add_group(held_a, (group_pos == 2'd2) ? held_b : 8'h00, 8'h00);
      sum_now = frame_sum;
      add_char(ChBase + {2'b00, sum_now[11:6]});
      add_char(ChBase + {2'b00, sum_now[5:0]});
      add_char(ChCr);
      clear_frame();
    end
    foreach (run_chars[i])
      expected_chars.push_back('{ch: run_chars[i], tail: (i == run_chars.size() - 1)});
  endtask

  always @(posedge clk) begin : driver
    frame_item_t nxt;
    logic        busy;
    busy = in_tvalid;
    if (in_tvalid && in_tready) begin
      encode_item(in_tdata[7:0], in_tdata[15:8], in_tuser[0], in_tuser[1], in_tlast);
      busy = 1'b0;
    end
    // Hold an offered item until taken; otherwise offer the next one or idle
    if (!busy) begin
      if (pending_items.size() > 0 && (calm || $urandom_range(99) >= 6)) begin
        nxt = pending_items.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {nxt.data, nxt.cmd};
        in_tuser  <= {nxt.first, nxt.has_data};
        in_tlast  <= nxt.last;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : monitor
    frame_char_t want;
    if (out_tvalid && out_tready) begin
      if (expected_chars.size() == 0) begin
        errors++;
        if (errors <= 20)
          $display("%0t: extra character, expected none, actual %h last %b",
                   $time, out_tdata, out_tlast);
      end else begin
        want = expected_chars.pop_front();
        if (out_tdata !== want.ch) begin
          errors++;
          if (errors <= 20)
            $display("%0t: out_char expected %h actual %h", $time, want.ch, out_tdata);
        end
        if (out_tlast !== want.tail) begin
          errors++;
          if (errors <= 20)
            $display("%0t: last_of_run expected %b actual %b", $time, want.tail, out_tlast);
        end
      end
    end
    // Hold off once for a long stretch so the input side backs up
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_armed && !hold_done && out_tvalid) begin
      hold_left = LongHold;
      hold_done = 1'b1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(99) >= 6);
    end
  end

  task automatic push_item(input logic [7:0] cmd, input logic [7:0] data,
                           input logic has_data, input logic first, input logic last);
    pending_items.push_back('{cmd: cmd, data: data, has_data: has_data,
                              first: first, last: last});
  endtask

  task automatic settle();
    while (pending_items.size() != 0 || in_tvalid || expected_chars.size() != 0)
      @(posedge clk);
    // A trailing item may cause nothing and still be in flight
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_address(input logic [4:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    dev_address = value;
    @(negedge clk);
  endtask

  // Mostly well-formed frames with random content; some noise and broken frames
  task automatic add_random_frames(input int target);
    int          counted;
    int          kind;
    int          nbytes;
    logic [31:0] bits;
    logic [7:0]  cmd;
    logic [7:0]  d;
    logic        keep_first;
    logic        keep_last;
    logic        split_first;
    logic        split_last;
    counted = 0;
    while (counted < target) begin
      kind = $urandom_range(99);
      if (kind < 5) begin
        bits = $urandom;
        push_item(bits[7:0], bits[15:8], bits[16], bits[17], bits[18]);
        if (bits[18:16] != 3'b000)
          counted++;
      end else begin
        keep_first = !(kind >= 5 && kind < 10);
        keep_last  = !(kind >= 10 && kind < 14);
        nbytes = ($urandom_range(9) < 7) ? $urandom_range(4) : $urandom_range(5, 12);
        cmd = 8'($urandom_range(255));
        if (nbytes == 0) begin
          if (keep_first && keep_last && $urandom_range(1) == 1) begin
            push_item(cmd, 8'($urandom_range(255)), 1'b0, 1'b1, 1'b1);
            counted++;
          end else begin
            if (keep_first) begin
              push_item(cmd, 8'($urandom_range(255)), 1'b0, 1'b1, 1'b0);
              counted++;
            end
            if (keep_last) begin
              push_item(8'($urandom_range(255)), 8'($urandom_range(255)),
                        1'b0, 1'b0, 1'b1);
              counted++;
            end
          end
        end else begin
          split_first = keep_first && ($urandom_range(3) == 0);
          split_last  = keep_last && ($urandom_range(3) == 0);
          if (split_first) begin
            push_item(cmd, 8'($urandom_range(255)), 1'b0, 1'b1, 1'b0);
            counted++;
          end
          for (int i = 0; i < nbytes; i++) begin
            if ($urandom_range(19) == 0)
              push_item(8'($urandom_range(255)), 8'($urandom_range(255)),
                        1'b0, 1'b0, 1'b0);
            d = 8'($urandom_range(255));
            if ($urandom_range(7) == 0)
              d = ($urandom_range(1) == 1) ? 8'hFF : 8'h00;
            push_item((i == 0) ? cmd : 8'($urandom_range(255)), d, 1'b1,
                      (i == 0) && keep_first && !split_first,
                      (i == nbytes - 1) && keep_last && !split_last);
            counted++;
          end
          if (split_last) begin
            push_item(8'($urandom_range(255)), 8'($urandom_range(255)),
                      1'b0, 1'b0, 1'b1);
            counted++;
          end
        end
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Address at its reset value
    push_item(8'hFF, 8'h00, 1'b0, 1'b1, 1'b1);
    push_item(8'h41, 8'h12, 1'b1, 1'b1, 1'b1);
    settle();

    write_address(5'd0);
    push_item(8'h00, 8'hFF, 1'b1, 1'b1, 1'b0);
    push_item(8'hFF, 8'h00, 1'b1, 1'b0, 1'b0);
    push_item(8'h5A, 8'hFF, 1'b1, 1'b0, 1'b0);
    push_item(8'hA5, 8'h80, 1'b1, 1'b0, 1'b1);   // one byte left to pad
    push_item(8'h7E, 8'hAA, 1'b1, 1'b1, 1'b0);
    push_item(8'h00, 8'h55, 1'b1, 1'b0, 1'b0);
    push_item(8'hFF, 8'h00, 1'b0, 1'b0, 1'b1);   // two bytes left to pad
    push_item(8'h5A, 8'hA5, 1'b0, 1'b0, 1'b0);   // nothing to do
    push_item(8'h81, 8'hC3, 1'b1, 1'b1, 1'b1);   // header, padded group, trailer
    push_item(8'h24, 8'h01, 1'b1, 1'b1, 1'b0);
    push_item(8'h24, 8'h02, 1'b1, 1'b0, 1'b0);
    push_item(8'h40, 8'h03, 1'b1, 1'b1, 1'b0);   // reopen while a frame is open
    push_item(8'h00, 8'h04, 1'b1, 1'b0, 1'b1);
    push_item(8'h00, 8'h10, 1'b1, 1'b0, 1'b0);   // frame without a header
    push_item(8'h00, 8'h20, 1'b1, 1'b0, 1'b0);
    push_item(8'h00, 8'h30, 1'b1, 1'b0, 1'b0);
    push_item(8'h00, 8'h3F, 1'b1, 1'b0, 1'b1);
    push_item(8'h12, 8'hFF, 1'b1, 1'b1, 1'b0);
    push_item(8'h34, 8'hFF, 1'b1, 1'b0, 1'b0);
    push_item(8'h56, 8'hFF, 1'b1, 1'b0, 1'b1);   // full group, then trailer
    push_item(8'hC0, 8'h00, 1'b0, 1'b1, 1'b1);   // empty frame
    push_item(8'h00, 8'h00, 1'b0, 1'b0, 1'b1);   // trailer alone
    push_item(8'hFF, 8'hFF, 1'b0, 1'b1, 1'b0);
    push_item(8'hFF, 8'hFF, 1'b0, 1'b0, 1'b1);
    settle();

    write_address(5'd25);
    add_random_frames(45);
    settle();

    write_address(5'd31);
    hold_armed = 1'b1;
    add_random_frames(45);
    settle();

    write_address(5'($urandom_range(2, 24)));
    add_random_frames(45);
    settle();

    write_address(5'd0);
    add_random_frames(45);
    settle();

    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
